// File: src/ratn_pkg.sv
// Shared control type for the rational_normalize pipeline.
package ratn_pkg;

	// Control that travels with each transaction through the pipe.
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero_den;
		logic zero_num;
	} ratn_ctl_t;

endpackage

// File: src/ratn_divstep.sv
// One restoring-division bit step shared by both quotient pipelines.
module ratn_divstep import ratn_pkg::*; #(
	parameter int W = 32
) (
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] dvd_i,
	input  logic [W-1:0] dvs_i,
	output logic [W-1:0] rem_o,
	output logic [W-1:0] dvd_o
);
	logic [W:0] trial;

	// shift in next dividend bit, subtract if it fits, quotient bit enters dividend LSB
	always_comb begin
		trial = {rem_i, dvd_i[W-1]} - {1'b0, dvs_i};
		if (!trial[W]) begin
			rem_o = trial[W-1:0];
			dvd_o = {dvd_i[W-2:0], 1'b1};
		end else begin
			rem_o = {rem_i[W-2:0], dvd_i[W-1]};
			dvd_o = {dvd_i[W-2:0], 1'b0};
		end
	end
endmodule

// File: src/rational_normalize.sv
// Top level: fraction reduction by greatest common divisor, fully pipelined.
//
// Usage: present num_in/den_in on s_axis_tdata; one result per transaction
// appears on m_axis_tdata in the same order. tdata layouts are listed at the ports.
// A transaction may be accepted on every cycle while s_axis_tready is high.
// Stages: 1 magnitude stage, then WORD_BITS*2 gcd steps (Euclid would need
// WORD_BITS divider bit steps per iteration, so the gcd uses the binary
// method: one subtract/shift per stage, 2*WORD_BITS stages bound it),
// then WORD_BITS division stages, each one bit step of a restoring divider,
// dividing both magnitudes by the gcd in parallel, then an output stage
// that restores the sign and saturates.
// Throughput: one transaction per cycle while the output is not stalled; the
// rate is set by the pipeline clocking, every stage being one subtract and
// compare.
// Reset clears all valid bits; payload is not reset.
// When m_axis_tvalid is high and m_axis_tready low the whole pipe holds; s_axis_tready
// follows m_axis_tready or an empty output slot, so nothing is lost or repeated.
module rational_normalize import ratn_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [W-1:0] num_in, [2W-1:W] den_in
	input  logic [2*WORD_BITS-1:0] s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [W-1:0] num_out, [2W-2:W] den_out, [2W-1] zero_den
	output logic [2*WORD_BITS-1:0] m_axis_tdata
);
	localparam int W  = WORD_BITS;
	localparam int GS = 2 * W;
	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

	logic adv;
	assign adv = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = adv;

	// Stage 1: magnitudes and sign
	logic [W-1:0] a_s1, b_s1;
	ratn_ctl_t    ctl_s1;
	logic [W-1:0] ni, di;
	assign ni = s_axis_tdata[W-1:0];
	assign di = s_axis_tdata[2*W-1:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid    <= s_axis_tvalid;
			ctl_s1.neg      <= ni[W-1] ^ di[W-1];
			ctl_s1.zero_den <= (di == '0);
			ctl_s1.zero_num <= (ni == '0);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= ni[W-1] ? (~ni + 1'b1) : ni;
			b_s1 <= di[W-1] ? (~di + 1'b1) : di;
		end
	end

	// Binary gcd stages: u,v shrink; k counts common twos; originals ride along
	localparam int KW = $clog2(W + 1);
	logic [W-1:0]  gu [GS+1];
	logic [W-1:0]  gv [GS+1];
	logic [KW-1:0] gk [GS+1];
	logic [W-1:0]  oa [GS+1];
	logic [W-1:0]  ob [GS+1];
	ratn_ctl_t     gc [GS+1];

	// zero operands are replaced by one so the loop stays defined
	assign gu[0] = (a_s1 == '0) ? {{(W-1){1'b0}}, 1'b1} : a_s1;
	assign gv[0] = (b_s1 == '0) ? {{(W-1){1'b0}}, 1'b1} : b_s1;
	assign gk[0] = '0;
	assign oa[0] = a_s1;
	assign ob[0] = b_s1;
	assign gc[0] = ctl_s1;

	for (genvar i = 0; i < GS; i++) begin : g_gcd
		logic [W-1:0]  nu, nv;
		logic [KW-1:0] nk;
		// one step: finish (clear v) when u equals v or v is zero, strip shared twos, strip lone twos, or subtract and halve
		always_comb begin
			nu = gu[i];
			nv = gv[i];
			nk = gk[i];
			if (gu[i] == gv[i] || gv[i] == '0) begin
				nu = gu[i];
				nv = '0;
			end else if (!gu[i][0] && !gv[i][0]) begin
				nu = gu[i] >> 1;
				nv = gv[i] >> 1;
				nk = gk[i] + 1'b1;
			end else if (!gu[i][0]) begin
				nu = gu[i] >> 1;
			end else if (!gv[i][0]) begin
				nv = gv[i] >> 1;
			end else if (gu[i] > gv[i]) begin
				nu = (gu[i] - gv[i]) >> 1;
			end else begin
				nv = (gv[i] - gu[i]) >> 1;
			end
		end
		logic [W-1:0]  u_q, v_q, a_q, b_q;
		logic [KW-1:0] k_q;
		ratn_ctl_t     c_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_q <= '0;
			end else if (adv) begin
				c_q <= gc[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				u_q <= nu;
				v_q <= nv;
				k_q <= nk;
				a_q <= oa[i];
				b_q <= ob[i];
			end
		end
		assign gu[i+1] = u_q;
		assign gv[i+1] = v_q;
		assign gk[i+1] = k_q;
		assign oa[i+1] = a_q;
		assign ob[i+1] = b_q;
		assign gc[i+1] = c_q;
	end

	// Division stages: both magnitudes divided by g = u << k
	logic [W-1:0] g_div;
	assign g_div = gu[GS] << gk[GS];

	logic [W-1:0] ra [W+1];
	logic [W-1:0] qa [W+1];
	logic [W-1:0] rb [W+1];
	logic [W-1:0] qb [W+1];
	logic [W-1:0] dg [W+1];
	ratn_ctl_t    dc [W+1];
	assign ra[0] = '0;
	assign qa[0] = oa[GS];
	assign rb[0] = '0;
	assign qb[0] = ob[GS];
	assign dg[0] = g_div;
	assign dc[0] = gc[GS];

	for (genvar j = 0; j < W; j++) begin : g_div_st
		logic [W-1:0] nra, nqa, nrb, nqb;
		ratn_divstep #(.W(W)) u_da (
			.rem_i(ra[j]), .dvd_i(qa[j]), .dvs_i(dg[j]), .rem_o(nra), .dvd_o(nqa));
		ratn_divstep #(.W(W)) u_db (
			.rem_i(rb[j]), .dvd_i(qb[j]), .dvs_i(dg[j]), .rem_o(nrb), .dvd_o(nqb));
		logic [W-1:0] ra_q, qa_q, rb_q, qb_q, g_q;
		ratn_ctl_t    c_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_q <= '0;
			end else if (adv) begin
				c_q <= dc[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ra_q <= nra;
				qa_q <= nqa;
				rb_q <= nrb;
				qb_q <= nqb;
				g_q  <= dg[j];
			end
		end
		assign ra[j+1] = ra_q;
		assign qa[j+1] = qa_q;
		assign rb[j+1] = rb_q;
		assign qb[j+1] = qb_q;
		assign dg[j+1] = g_q;
		assign dc[j+1] = c_q;
	end

	// Output stage: sign, saturation and special cases
	logic [W-1:0] qn, qd, num_o, den_o;
	ratn_ctl_t    fc;
	assign qn = qa[W];
	assign qd = qb[W];
	assign fc = dc[W];
	always_comb begin
		if (fc.zero_den || fc.zero_num) begin
			num_o = '0;
			den_o = {{(W-1){1'b0}}, 1'b1};
		end else begin
			den_o = (qd > MAXPOS) ? MAXPOS : qd;
			if (fc.neg) begin
				num_o = (qn > MINNEG) ? MINNEG : (~qn + 1'b1);
			end else begin
				num_o = (qn > MAXPOS) ? MAXPOS : qn;
			end
		end
	end

	logic [2*W-1:0] out_q;
	logic           ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= fc.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {fc.zero_den, den_o[W-2:0], num_o};
		end
	end
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = out_q;

	// Checks
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2*W-2:W] != '0) else $error("den zero");
	a_zd_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2*W-1]) |-> m_axis_tdata[W-1:0] == '0)
		else $error("zero_den result not 0/1");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_gdiv: assert property (@(posedge clk) disable iff (!arst_n)
		gc[GS].valid |-> g_div != '0) else $error("gcd zero");
endmodule
